/* rtl/txq_pkg.sv */
`timescale 1ns / 1ps

package txq_pkg;

    localparam int TX_DEPTH_DEF   = 64;
    localparam int WAIT_DEPTH_DEF = 32;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_ACK_CLIENT = 2'd0,
        K_ACK_NOTIFY = 2'd1,
        K_SEND       = 2'd2,
        K_DROP       = 2'd3
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic [7:0] task_id;
        logic [7:0] data_byte;
        logic       tx_empty;
        logic       tx_holding_full;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ack_task;
        logic [7:0] send_byte;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] data_byte;
    } t_wait;

endpackage

/* rtl/txq_ram.sv */
`timescale 1ns / 1ps

module txq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tx_queue_with_waitlist.sv */
`timescale 1ns / 1ps
// S_WR registers a write's ack or drop (none if it joins the waitlist); a send then takes
// S_TXRD and S_SEND. S_RDY acks a ready notice, then may send likewise or move waitlist
// entries via S_WRD, S_MOVE. One word at a time; S_TXRD and S_WRD await the RAM reads.
// Output stalls hold the sequencer; the next word is taken while the last result waits.
// Reset (synchronous, active low) empties both FIFOs and clears busy; no RAM clearing.
module tx_queue_with_waitlist #(
    parameter int TX_DEPTH   = txq_pkg::TX_DEPTH_DEF,
    parameter int WAIT_DEPTH = txq_pkg::WAIT_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  txq_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output txq_pkg::t_out o_out
);
    import txq_pkg::*;

    localparam int TX_AW   = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CW   = $clog2(TX_DEPTH + 1);
    localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_RDY,
        S_TXRD,
        S_SEND,
        S_WRD,
        S_MOVE
    } t_state;

    t_state             r_state,      n_state;
    t_in                r_item,       n_item;
    logic [TX_AW-1:0]   r_tx_head,    n_tx_head;
    logic [TX_AW-1:0]   r_tx_tail,    n_tx_tail;
    logic [TX_CW-1:0]   r_tx_count,   n_tx_count;
    logic [WAIT_AW-1:0] r_wait_head,  n_wait_head;
    logic [WAIT_AW-1:0] r_wait_tail,  n_wait_tail;
    logic [WAIT_CW-1:0] r_wait_count, n_wait_count;
    logic               r_busy,       n_busy;
    logic [1:0]         r_nres,       n_nres;
    logic               r_out_valid,  n_out_valid;
    t_out               r_out,        n_out;

    logic               w_slot;
    logic               w_tx_room;
    logic               w_send_now;
    logic               w_more;
    logic [TX_CW-1:0]   w_tx_cnt_new;
    logic [WAIT_CW-1:0] w_wait_cnt_new;
    logic [1:0]         w_nres_new;

    logic               w_tx_we;
    logic [TX_AW-1:0]   w_tx_waddr;
    logic [7:0]         w_tx_wdata;
    logic               w_tx_re;
    logic [7:0]         w_tx_rdata;
    logic               w_wait_we;
    t_wait              w_wait_wdata;
    logic               w_wait_re;
    t_wait              w_wait_rdata;

    txq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (w_tx_waddr),
        .i_wdata (w_tx_wdata),
        .i_re    (w_tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (w_tx_rdata)
    );

    txq_ram #(.WIDTH($bits(t_wait)), .DEPTH(WAIT_DEPTH)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_wait_we),
        .i_waddr (r_wait_tail),
        .i_wdata (w_wait_wdata),
        .i_re    (w_wait_re),
        .i_raddr (r_wait_head),
        .o_rdata (w_wait_rdata)
    );

    assign w_slot      = !r_out_valid || i_out_ready;
    assign w_tx_room   = r_tx_count < TX_CW'(TX_DEPTH);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_count   = r_tx_count;
        n_wait_head  = r_wait_head;
        n_wait_tail  = r_wait_tail;
        n_wait_count = r_wait_count;
        n_busy       = r_busy;
        n_nres       = r_nres;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        w_tx_we        = 1'b0;
        w_tx_waddr     = r_tx_tail;
        w_tx_wdata     = r_item.data_byte;
        w_tx_re        = 1'b0;
        w_wait_we      = 1'b0;
        w_wait_wdata   = '{task_id: r_item.task_id, data_byte: r_item.data_byte};
        w_wait_re      = 1'b0;
        w_send_now     = 1'b0;
        w_more         = 1'b0;
        w_tx_cnt_new   = r_tx_count;
        w_wait_cnt_new = r_wait_count;
        w_nres_new     = r_nres + 2'd1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = (i_in.op == OP_READY) ? S_RDY : S_WR;
                end
            end
            S_WR: begin
                if (w_slot) begin
                    w_tx_cnt_new = w_tx_room ? r_tx_count + 1'b1 : r_tx_count;
                    w_send_now   = !r_busy && !r_item.tx_holding_full && (w_tx_cnt_new != '0);
                    n_nres       = 2'd1;
                    if (w_tx_room) begin
                        w_tx_we     = 1'b1;
                        n_tx_tail   = (r_tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                          : r_tx_tail + 1'b1;
                        n_tx_count  = w_tx_cnt_new;
                        n_out_valid = 1'b1;
                        n_out       = '{kind: K_ACK_CLIENT, ack_task: r_item.task_id,
                                        send_byte: 8'h00, last: !w_send_now};
                    end else if (r_wait_count < WAIT_CW'(WAIT_DEPTH)) begin
                        w_wait_we    = 1'b1;
                        n_wait_tail  = (r_wait_tail == WAIT_AW'(WAIT_DEPTH - 1)) ? '0
                                                                               : r_wait_tail + 1'b1;
                        n_wait_count = r_wait_count + 1'b1;
                        n_nres       = 2'd0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: K_DROP, ack_task: r_item.task_id,
                                        send_byte: 8'h00, last: !w_send_now};
                    end
                    n_state = w_send_now ? S_TXRD : S_IDLE;
                end
            end
            S_RDY: begin
                if (w_slot) begin
                    w_send_now  = r_item.tx_empty && (r_tx_count != '0);
                    w_more      = (r_wait_count != '0) && w_tx_room;
                    n_busy      = 1'b0;
                    n_nres      = 2'd1;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: K_ACK_NOTIFY, ack_task: 8'h00, send_byte: 8'h00,
                                    last: !w_send_now && !w_more};
                    if (w_send_now) begin
                        n_state = S_TXRD;
                    end else if (w_more) begin
                        n_state = S_WRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TXRD: begin
                w_tx_re = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_slot) begin
                    w_more      = (r_item.op == OP_READY) && (r_wait_count != '0);
                    n_tx_head   = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
                    n_tx_count  = r_tx_count - 1'b1;
                    n_busy      = 1'b1;
                    n_nres      = w_nres_new;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: K_SEND, ack_task: 8'h00, send_byte: w_tx_rdata,
                                    last: !w_more};
                    n_state     = w_more ? S_WRD : S_IDLE;
                end
            end
            S_WRD: begin
                w_wait_re = 1'b1;
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                if (w_slot) begin
                    w_tx_cnt_new   = r_tx_count + 1'b1;
                    w_wait_cnt_new = r_wait_count - 1'b1;
                    w_more         = (w_nres_new != 2'd3) && (w_wait_cnt_new != '0)
                                     && (w_tx_cnt_new < TX_CW'(TX_DEPTH));
                    w_tx_we        = 1'b1;
                    w_tx_wdata     = w_wait_rdata.data_byte;
                    n_tx_tail      = (r_tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                         : r_tx_tail + 1'b1;
                    n_tx_count     = w_tx_cnt_new;
                    n_wait_head    = (r_wait_head == WAIT_AW'(WAIT_DEPTH - 1)) ? '0
                                                                             : r_wait_head + 1'b1;
                    n_wait_count   = w_wait_cnt_new;
                    n_nres         = w_nres_new;
                    n_out_valid    = 1'b1;
                    n_out          = '{kind: K_ACK_CLIENT, ack_task: w_wait_rdata.task_id,
                                       send_byte: 8'h00, last: !w_more};
                    n_state        = w_more ? S_WRD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_count   <= '0;
            r_wait_head  <= '0;
            r_wait_tail  <= '0;
            r_wait_count <= '0;
            r_busy       <= 1'b0;
            r_nres       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_tx_count   <= n_tx_count;
            r_wait_head  <= n_wait_head;
            r_wait_tail  <= n_wait_tail;
            r_wait_count <= n_wait_count;
            r_busy       <= n_busy;
            r_nres       <= n_nres;
            r_out_valid  <= n_out_valid;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= TX_CW'(TX_DEPTH))
        else $error("transmit FIFO count overflow");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait_count <= WAIT_CW'(WAIT_DEPTH))
        else $error("wait FIFO count overflow");

    a_move_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRD) |-> (r_wait_count != '0) && w_tx_room)
        else $error("waitlist move without entry or room");

    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == K_SEND)) |-> r_busy)
        else $error("send shown while not busy");

    a_send_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_tx_count != '0))
        else $error("send from empty transmit FIFO");
`endif

endmodule
